>>> rtl/core/b2da_pkg.sv
package b2da_pkg;

  localparam int unsigned DefValueWidth = 64;

  // High two bits of an ASCII digit in a 6-bit code ('0' = 6'b110000)
  localparam logic [1:0] DigitHi = 2'b11;

  typedef enum logic [1:0] {
    StIdle,
    StShift,
    StSkip,
    StEmit
  } state_e;

endpackage

>>> rtl/core/binary_to_decimal_ascii.sv
// Channel   Ports                           Handshake
// --------  ------------------------------  ----------------------------------
// in        value_i                         start_i && !busy_o at rising edge
// out       digit_char_o, last_o            valid_o, one cycle, no back-pressure
//
// Each word is shifted in through the shared add-3/shift unit (StShift),
// then leading zeros are dropped (StSkip), then the digits are emitted
// one per cycle (StEmit).
// busy_o is high from acceptance until the cycle after the last digit.
// Reset returns the sequencer to idle; the datapath needs no reset.
// The receiver cannot stall, so digits leave on consecutive cycles.
module binary_to_decimal_ascii
  import b2da_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = DefValueWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   valid_o,
  output logic [5:0]             digit_char_o,
  output logic                   last_o
);

  // decimal digits of 2^W-1: floor(W*log10(2)) + 1
  localparam int unsigned NumDigits = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int unsigned BcdWidth  = 4 * NumDigits;
  localparam int unsigned BitCntW   = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int unsigned DigCntW   = $clog2(NumDigits + 1);

  state_e state_q, state_d;
  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [BcdWidth-1:0]    bcd_q, bcd_d;
  logic [BcdWidth-1:0]    dabbled;
  logic [BitCntW-1:0]     bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0]     dig_cnt_q, dig_cnt_d;
  logic [3:0]             top_digit;

  // shared unit: add 3 to every digit of 5 or more
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        dabbled[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        dabbled[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  assign top_digit = bcd_q[BcdWidth-1 -: 4];

  always_comb begin
    state_d      = state_q;
    bin_d        = bin_q;
    bcd_d        = bcd_q;
    bit_cnt_d    = bit_cnt_q;
    dig_cnt_d    = dig_cnt_q;
    valid_o      = 1'b0;
    last_o       = 1'b0;
    digit_char_o = {DigitHi, top_digit};
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          bin_d     = value_i;
          bcd_d     = '0;
          bit_cnt_d = BitCntW'(VALUE_WIDTH - 1);
          state_d   = StShift;
        end
      end
      StShift: begin
        bcd_d = {dabbled[BcdWidth-2:0], bin_q[VALUE_WIDTH-1]};
        bin_d = {bin_q[VALUE_WIDTH-2:0], 1'b0};
        if (bit_cnt_q == '0) begin
          dig_cnt_d = DigCntW'(NumDigits);
          state_d   = StSkip;
        end else begin
          bit_cnt_d = bit_cnt_q - 1'b1;
        end
      end
      StSkip: begin
        // drop leading zeros, always keep the final digit
        if (top_digit == 4'd0 && dig_cnt_q > DigCntW'(1)) begin
          bcd_d     = {bcd_q[BcdWidth-5:0], 4'd0};
          dig_cnt_d = dig_cnt_q - 1'b1;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        valid_o   = 1'b1;
        last_o    = (dig_cnt_q == DigCntW'(1));
        bcd_d     = {bcd_q[BcdWidth-5:0], 4'd0};
        dig_cnt_d = dig_cnt_q - 1'b1;
        if (dig_cnt_q == DigCntW'(1)) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      bit_cnt_q <= '0;
      dig_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      dig_cnt_q <= dig_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign busy_o = (state_q != StIdle);

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o)
    else $error("digit strobe outside a conversion");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |=> !busy_o)
    else $error("still busy after last digit");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !valid_o))
    else $error("accepted word did not start a conversion");

  a_digits_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |=> valid_o)
    else $error("gap inside a digit run");

endmodule
